// File: rtl/core/firp_pkg.sv
// ----------------------------------------------------------------------------
// firp_pkg
// Shared sizes and control types of the programmable FIR filter.
// ----------------------------------------------------------------------------
package firp_pkg;

   // Filter dimensions.
   localparam int MAX_TAPS        = 64;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEF_WIDTH      = 16;

   // Fixed field widths of the ports.
   localparam int OUT_WIDTH       = 38;
   localparam int CFG_WIDTH       = 7;
   localparam int TAP_INDEX_WIDTH = 6;

   // Derived widths.
   localparam int IDX_WIDTH  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TAPS_WIDTH = $clog2(MAX_TAPS + 1);
   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;

   // Command that every cell of the tap chain sees.
   typedef struct packed {
      logic                       shift;
      logic                       rotate;
      logic                       load;
      logic [TAP_INDEX_WIDTH-1:0] load_index;
   } cell_ctrl_type;

   // Command to the multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic take;
   } mac_ctrl_type;

endpackage

// File: rtl/core/firp_cell.sv
// ----------------------------------------------------------------------------
// firp_cell
// One tap of the filter: a delayed sample and its coefficient.
// ----------------------------------------------------------------------------
module firp_cell (
   input  logic                                    clock,
   input  logic                                    reset,
   input  firp_pkg::cell_ctrl_type                 ctrl,
   input  logic [firp_pkg::IDX_WIDTH-1:0]          cell_index,
   input  logic signed [firp_pkg::COEF_WIDTH-1:0]  coef_wdata,
   input  logic signed [firp_pkg::SAMPLE_WIDTH-1:0] prev_sample,
   input  logic signed [firp_pkg::SAMPLE_WIDTH-1:0] next_sample,
   input  logic signed [firp_pkg::COEF_WIDTH-1:0]  next_coef,
   output logic signed [firp_pkg::SAMPLE_WIDTH-1:0] sample_q,
   output logic signed [firp_pkg::COEF_WIDTH-1:0]  coef_q
);

   logic signed [firp_pkg::SAMPLE_WIDTH-1:0] sample_ff;
   logic signed [firp_pkg::SAMPLE_WIDTH-1:0] sample_in;
   logic signed [firp_pkg::COEF_WIDTH-1:0]   coef_ff;
   logic signed [firp_pkg::COEF_WIDTH-1:0]   coef_in;
   logic                                     hit;

   // This cell is the target of a coefficient write.
   assign hit = (32'(ctrl.load_index) == 32'(cell_index));

   // Shift takes the newer neighbor's sample, rotate takes the next cell's pair, a load on a hit takes coef_wdata.
   always_comb begin
      sample_in = sample_ff;
      coef_in   = coef_ff;
      priority if (ctrl.shift) begin
         sample_in = prev_sample;
      end else if (ctrl.rotate) begin
         sample_in = next_sample;
         coef_in   = next_coef;
      end else if (ctrl.load && hit) begin
         coef_in = coef_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         coef_ff   <= '0;
      end else begin
         sample_ff <= sample_in;
         coef_ff   <= coef_in;
      end
   end

   assign sample_q = sample_ff;
   assign coef_q   = coef_ff;

endmodule

// File: rtl/core/firp_mac.sv
// ----------------------------------------------------------------------------
// firp_mac
// Multiply-accumulate unit at the head of the tap chain.
// ----------------------------------------------------------------------------
module firp_mac (
   input  logic                                     clock,
   input  logic                                     reset,
   input  firp_pkg::mac_ctrl_type                   ctrl,
   input  logic signed [firp_pkg::SAMPLE_WIDTH-1:0] sample,
   input  logic signed [firp_pkg::COEF_WIDTH-1:0]   coef,
   output logic signed [firp_pkg::OUT_WIDTH-1:0]    acc
);

   logic signed [firp_pkg::PROD_WIDTH-1:0] prod_ff;
   logic signed [firp_pkg::PROD_WIDTH-1:0] prod_in;
   logic                                   take_ff;
   logic                                   take_in;
   logic signed [firp_pkg::OUT_WIDTH-1:0]  acc_ff;
   logic signed [firp_pkg::OUT_WIDTH-1:0]  acc_in;

   // The product is registered, then added in the next cycle.
   always_comb begin
      prod_in = sample * coef;
      take_in = ctrl.take && !ctrl.clear;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (take_ff) begin
         acc_in = acc_ff + firp_pkg::OUT_WIDTH'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         take_ff <= 1'b0;
         acc_ff  <= '0;
      end else begin
         take_ff <= take_in;
         acc_ff  <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// File: rtl/core/fir_filter_programmable.sv
// ----------------------------------------------------------------------------
// fir_filter_programmable
// Programmable direct-form FIR filter over a ring of tap cells.
// A request word with mode 0 writes one coefficient and gives no response.
// A word with mode 1 shifts its sample into the chain, which then rotates
// once all the way round past one shared multiplier in the run state; the
// flush and done states follow, and from done the sum goes to the output
// register and the block returns to idle. req_stall is high while a
// sample is being worked on. A finished response waits in the output
// register while rsp_stall is high; the block still takes new request
// words meanwhile and holds the next result in the done state until the
// output register is free. The user must write tap_count through csr_valid /
// csr_ready only while the block is idle; the block does not enforce it.
// Reset clears all samples, coefficients and tap_count to zero.
// ----------------------------------------------------------------------------
module fir_filter_programmable (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_mode,
   input  logic [firp_pkg::TAP_INDEX_WIDTH-1:0]      req_tap_index,
   input  logic signed [firp_pkg::COEF_WIDTH-1:0]    req_coefficient,
   input  logic signed [firp_pkg::SAMPLE_WIDTH-1:0]  req_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [firp_pkg::OUT_WIDTH-1:0]     rsp_filtered,
   output logic                                      rsp_no_taps_error,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [firp_pkg::CFG_WIDTH-1:0]            csr_tap_count
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   localparam logic [firp_pkg::IDX_WIDTH-1:0] LAST_TAP =
      firp_pkg::IDX_WIDTH'(firp_pkg::MAX_TAPS - 1);

   logic [1:0]                              state_ff;
   logic [1:0]                              state_in;
   logic [firp_pkg::IDX_WIDTH-1:0]          cnt_ff;
   logic [firp_pkg::IDX_WIDTH-1:0]          cnt_in;
   logic [firp_pkg::TAPS_WIDTH-1:0]         taps_ff;
   logic [firp_pkg::TAPS_WIDTH-1:0]         taps_in;
   logic [firp_pkg::CFG_WIDTH-1:0]          tap_count_ff;
   logic                                    rsp_valid_ff;
   logic                                    rsp_valid_in;
   logic signed [firp_pkg::OUT_WIDTH-1:0]   rsp_filtered_ff;
   logic                                    rsp_error_ff;
   logic                                    req_take;
   logic                                    rsp_load;
   firp_pkg::cell_ctrl_type                 cell_ctrl;
   firp_pkg::mac_ctrl_type                  mac_ctrl;
   logic signed [firp_pkg::OUT_WIDTH-1:0]   acc;

   logic signed [firp_pkg::SAMPLE_WIDTH-1:0] sample_q [firp_pkg::MAX_TAPS];
   logic signed [firp_pkg::COEF_WIDTH-1:0]   coef_q   [firp_pkg::MAX_TAPS];

   // Configuration register, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         tap_count_ff <= csr_tap_count;
      end
   end

   // Request handshake.
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer: one full rotation of the chain per sample word.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      taps_in  = taps_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take && req_mode) begin
               state_in = S_RUN;
               cnt_in   = '0;
               if (32'(tap_count_ff) > firp_pkg::MAX_TAPS) begin
                  taps_in = firp_pkg::TAPS_WIDTH'(firp_pkg::MAX_TAPS);
               end else begin
                  taps_in = firp_pkg::TAPS_WIDTH'(tap_count_ff);
               end
            end
         end
         S_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_TAP) begin
               state_in = S_FLUSH;
               cnt_in   = '0;
            end
         end
         S_FLUSH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         taps_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         taps_ff  <= taps_in;
      end
   end

   // Commands for the chain and the accumulator.
   always_comb begin
      cell_ctrl.shift      = req_take && req_mode;
      cell_ctrl.rotate     = (state_ff == S_RUN);
      cell_ctrl.load       = req_take && !req_mode;
      cell_ctrl.load_index = req_tap_index;
      mac_ctrl.clear       = req_take && req_mode;
      mac_ctrl.take        = (state_ff == S_RUN) && (32'(cnt_ff) < 32'(taps_ff));
   end

   // Ring of tap cells; cell 0 holds the newest sample.
   for (genvar i = 0; i < firp_pkg::MAX_TAPS; i++) begin : g_cell
      localparam int NEXT = (i + 1) % firp_pkg::MAX_TAPS;
      logic signed [firp_pkg::SAMPLE_WIDTH-1:0] prev_sample;
      if (i == 0) begin : g_head
         assign prev_sample = req_sample;
      end else begin : g_body
         assign prev_sample = sample_q[i-1];
      end
      firp_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .cell_index  (firp_pkg::IDX_WIDTH'(i)),
         .coef_wdata  (req_coefficient),
         .prev_sample (prev_sample),
         .next_sample (sample_q[NEXT]),
         .next_coef   (coef_q[NEXT]),
         .sample_q    (sample_q[i]),
         .coef_q      (coef_q[i])
      );
   end

   // Shared multiplier at the head of the ring.
   firp_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (sample_q[0]),
      .coef   (coef_q[0]),
      .acc    (acc)
   );

   // Output register; a waiting word does not block new requests.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_filtered_ff <= acc;
         rsp_error_ff    <= (taps_ff == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered      = rsp_filtered_ff;
   assign rsp_no_taps_error = rsp_error_ff;

`ifndef SYNTHESIS
   // A sample word starts a rotation from the first tap.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_mode) |=> (state_ff == S_RUN) && (cnt_ff == '0))
      else $error("sample word did not start a rotation");

   // The last tap of the rotation is followed by the flush cycle.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_RUN) && (cnt_ff == LAST_TAP)) |=> (state_ff == S_FLUSH))
      else $error("rotation did not end after the last tap");

   // A response word only comes out of the done state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response word appeared without a finished sum");

   // With no taps in use the sum is zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff) |-> (rsp_filtered_ff == '0))
      else $error("no-taps response carries a nonzero sum");
`endif

endmodule

// File: tb/fir_filter_programmable_test.sv
// ----------------------------------------------------------------------------
// fir_filter_programmable_test
// Self-checking testbench of the programmable FIR filter. A driver offers
// request words from a queue, a monitor predicts every filter output from
// its own copy of the coefficients, delay line and tap count, and checks
// each response word in order. The run steps through several tap-count
// settings and idle patterns, including a long output hold-off.
// ----------------------------------------------------------------------------
module fir_filter_programmable_test;

   // Run sizes.
   localparam int SETTLE_CYCLES   = 80;
   localparam int HOLD_CYCLES     = 300;
   localparam int QUIET_LIMIT     = 4000;
   localparam int PHASE_WORDS     = 128;
   localparam int PHASE_COUNT     = 8;
   localparam int RANDOM_SETTING  = -1;

   typedef enum logic {
      LOAD_COEF   = 1'b0,
      PUSH_SAMPLE = 1'b1
   } fir_mode_type;

   typedef struct packed {
      logic                                        mode;
      logic [firp_pkg::TAP_INDEX_WIDTH-1:0]        tap_index;
      logic signed [firp_pkg::COEF_WIDTH-1:0]      coefficient;
      logic signed [firp_pkg::SAMPLE_WIDTH-1:0]    sample;
   } fir_word_type;

   typedef struct packed {
      logic signed [firp_pkg::OUT_WIDTH-1:0] filtered;
      logic                                  no_taps_error;
   } fir_result_type;

   // Ports of the block.
   logic                                        clock = 1'b0;
   logic                                        reset = 1'b1;
   logic                                        req_valid = 1'b0;
   logic                                        req_stall;
   logic                                        req_mode = 1'b0;
   logic [firp_pkg::TAP_INDEX_WIDTH-1:0]        req_tap_index = '0;
   logic signed [firp_pkg::COEF_WIDTH-1:0]      req_coefficient = '0;
   logic signed [firp_pkg::SAMPLE_WIDTH-1:0]    req_sample = '0;
   logic                                        rsp_valid;
   logic                                        rsp_stall = 1'b0;
   logic signed [firp_pkg::OUT_WIDTH-1:0]       rsp_filtered;
   logic                                        rsp_no_taps_error;
   logic                                        csr_valid = 1'b0;
   logic                                        csr_ready;
   logic [firp_pkg::CFG_WIDTH-1:0]              csr_tap_count = '0;

   // Stimulus and prediction state.
   fir_word_type                                pending_words[$];
   fir_result_type                              expected_outputs[$];
   logic signed [firp_pkg::SAMPLE_WIDTH-1:0]    sample_history[firp_pkg::MAX_TAPS];
   logic signed [firp_pkg::COEF_WIDTH-1:0]      coef_copy[firp_pkg::MAX_TAPS];
   logic [firp_pkg::CFG_WIDTH-1:0]              taps_in_use = '0;
   bit                                          req_taken = 1'b0;
   int                                          words_queued = 0;
   int                                          words_accepted = 0;
   int                                          outputs_checked = 0;
   int                                          coef_loads = 0;
   int                                          settings_used = 0;
   int                                          failures = 0;
   int                                          quiet_cycles = 0;
   int                                          send_idle_pct = 0;
   int                                          recv_stall_pct = 0;
   int                                          hold_requests = 0;
   int                                          holds_done = 0;
   int                                          hold_left = 0;

   fir_filter_programmable uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_tap_index     (req_tap_index),
      .req_coefficient   (req_coefficient),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered      (rsp_filtered),
      .rsp_no_taps_error (rsp_no_taps_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_tap_count     (csr_tap_count)
   );

   // Free-running clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shift a sample into the delay line and form the expected filter output.
   function automatic fir_result_type filter_sample(
      logic signed [firp_pkg::SAMPLE_WIDTH-1:0] value);
      fir_result_type out_word;
      longint         acc;
      int             taps;
      for (int i = firp_pkg::MAX_TAPS - 1; i > 0; i--) begin
         sample_history[i] = sample_history[i-1];
      end
      sample_history[0] = value;
      taps = (taps_in_use > firp_pkg::MAX_TAPS) ? firp_pkg::MAX_TAPS : int'(taps_in_use);
      acc = 0;
      for (int i = 0; i < taps; i++) begin
         acc += longint'(coef_copy[i]) * longint'(sample_history[i]);
      end
      out_word.filtered      = acc[firp_pkg::OUT_WIDTH-1:0];
      out_word.no_taps_error = (taps == 0);
      return out_word;
   endfunction

   // One of the four corner values of a Q1.15 field.
   function automatic logic signed [15:0] corner_value();
      case ($urandom_range(3))
         0: begin
            return 16'sh8000;
         end
         1: begin
            return 16'sh7fff;
         end
         2: begin
            return 16'sh0000;
         end
         default: begin
            return 16'shffff;
         end
      endcase
   endfunction

   // A random request word; about a quarter of them load a coefficient.
   function automatic fir_word_type random_word();
      fir_word_type w;
      w.mode        = ($urandom_range(99) < 25) ? LOAD_COEF : PUSH_SAMPLE;
      w.tap_index   = firp_pkg::TAP_INDEX_WIDTH'($urandom);
      w.coefficient = firp_pkg::COEF_WIDTH'($urandom);
      w.sample      = firp_pkg::SAMPLE_WIDTH'($urandom);
      if ($urandom_range(7) == 0) begin
         w.sample = corner_value();
      end
      if ($urandom_range(7) == 0) begin
         w.coefficient = corner_value();
      end
      return w;
   endfunction

   task automatic queue_word(fir_word_type w);
      pending_words = {pending_words, w};
      words_queued++;
   endtask

   // Wait until every word is taken and every output has arrived, then let
   // the block settle.
   task automatic drain_filter();
      do begin
         @(negedge clock);
      end while (words_accepted != words_queued || expected_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the tap count through the register port.
   task automatic write_tap_count(logic [firp_pkg::CFG_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_tap_count <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // Request driver: a word stays put until it is taken.
   always @(negedge clock) begin
      fir_word_type w;
      bit           offer;
      if (!reset && (!req_valid || req_taken)) begin
         offer = (pending_words.size() != 0) && ($urandom_range(99) >= send_idle_pct);
         if (offer) begin
            w = pending_words.pop_front();
            req_mode        <= w.mode;
            req_tap_index   <= w.tap_index;
            req_coefficient <= w.coefficient;
            req_sample      <= w.sample;
         end
         req_valid <= offer;
      end
   end

   // Response side: random stalls, and a long hold-off when one is asked for.
   always @(negedge clock) begin
      bit stall_now;
      if (reset) begin
         stall_now = 1'b0;
      end else if (hold_left > 0) begin
         stall_now = 1'b1;
         hold_left--;
      end else if (holds_done != hold_requests) begin
         stall_now = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         holds_done++;
      end else begin
         stall_now = ($urandom_range(99) < recv_stall_pct);
      end
      rsp_stall <= stall_now;
   end

   // Monitor: track register writes, predict on taken words, check outputs.
   always @(posedge clock) begin
      fir_word_type   w;
      fir_result_type want;
      fir_result_type next_out;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            taps_in_use = csr_tap_count;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               $error("response word with no sample pending: filtered %0d", rsp_filtered);
               failures++;
            end else begin
               want = expected_outputs.pop_front();
               outputs_checked++;
               if (rsp_filtered !== want.filtered) begin
                  $error("filtered mismatch: expected %0d, actual %0d",
                         want.filtered, rsp_filtered);
                  failures++;
               end
               if (rsp_no_taps_error !== want.no_taps_error) begin
                  $error("no_taps_error mismatch: expected %0d, actual %0d",
                         want.no_taps_error, rsp_no_taps_error);
                  failures++;
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            w = '{req_mode, req_tap_index, req_coefficient, req_sample};
            words_accepted++;
            if (w.mode == LOAD_COEF) begin
               if (w.tap_index < firp_pkg::MAX_TAPS) begin
                  coef_copy[w.tap_index] = w.coefficient;
               end
               coef_loads++;
            end else begin
               next_out = filter_sample(w.sample);
               expected_outputs = {expected_outputs, next_out};
            end
         end
      end
   end

   // Watchdog on cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("FAIL fir_filter_programmable");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      int setting_list[PHASE_COUNT];
      int setting;
      setting_list = '{64, 1, 127, 0, RANDOM_SETTING, 33, RANDOM_SETTING, 64};
      foreach (sample_history[i]) begin
         sample_history[i] = '0;
         coef_copy[i]      = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset tap count of zero every sample flags the error.
      queue_word(fir_word_type'{PUSH_SAMPLE, 6'd63, 16'sh8000, 16'sh7fff});
      queue_word(fir_word_type'{LOAD_COEF, 6'd0, 16'sh8000, 16'sh7fff});
      queue_word(fir_word_type'{LOAD_COEF, 6'd63, 16'sh7fff, 16'sh8000});
      queue_word(fir_word_type'{LOAD_COEF, 6'd1, 16'sh7fff, 16'sh0000});
      queue_word(fir_word_type'{PUSH_SAMPLE, 6'd0, 16'sh7fff, 16'sh8000});
      drain_filter();

      // Full length with corner samples and coefficients.
      write_tap_count(7'd64);
      queue_word(fir_word_type'{PUSH_SAMPLE, 6'd5, 16'sh1234, 16'sh8000});
      queue_word(fir_word_type'{PUSH_SAMPLE, 6'd0, 16'sh0000, 16'sh8000});
      queue_word(fir_word_type'{PUSH_SAMPLE, 6'd0, 16'sh0000, 16'sh7fff});
      queue_word(fir_word_type'{LOAD_COEF, 6'd2, 16'shffff, 16'sh5555});
      queue_word(fir_word_type'{LOAD_COEF, 6'd62, 16'sh8000, 16'sh0000});
      queue_word(fir_word_type'{PUSH_SAMPLE, 6'd0, 16'sh0000, 16'sh0000});
      queue_word(fir_word_type'{PUSH_SAMPLE, 6'd0, 16'sh0000, 16'shffff});
      queue_word(fir_word_type'{PUSH_SAMPLE, 6'd0, 16'sh0000, 16'sh0001});
      for (int i = 0; i < 3; i++) begin
         queue_word(fir_word_type'{PUSH_SAMPLE, 6'd0, 16'sh0000, 16'sh8000});
      end
      drain_filter();

      // Single tap.
      write_tap_count(7'd1);
      queue_word(fir_word_type'{PUSH_SAMPLE, 6'd0, 16'sh0000, 16'sh7fff});
      queue_word(fir_word_type'{PUSH_SAMPLE, 6'd0, 16'sh0000, 16'sh8000});
      drain_filter();

      // Random phases over tap counts and idle patterns.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         setting = (setting_list[p] == RANDOM_SETTING) ? $urandom_range(2, 63)
                                                       : setting_list[p];
         write_tap_count(setting[firp_pkg::CFG_WIDTH-1:0]);
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 56;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 56;
            end
            default: begin
               send_idle_pct  = 17;
               recv_stall_pct = 17;
            end
         endcase
         for (int i = 0; i < PHASE_WORDS; i++) begin
            queue_word(random_word());
         end
         // Hold the output back while the sender keeps offering words.
         if (p == 4) begin
            hold_requests++;
         end
         drain_filter();
      end

      @(negedge clock);
      $display("Checked %0d filter outputs and %0d coefficient loads over %0d tap counts,",
               outputs_checked, coef_loads, settings_used);
      $display("with sender gaps, receiver stalls and one long output hold-off.");
      if (failures == 0) begin
         $display("PASS fir_filter_programmable");
      end else begin
         $display("FAIL fir_filter_programmable");
      end
      $finish;
   end

endmodule

// File: fir_filter_programmable.f
rtl/core/firp_pkg.sv
rtl/core/firp_cell.sv
rtl/core/firp_mac.sv
rtl/core/fir_filter_programmable.sv
tb/fir_filter_programmable_test.sv
